// ----- hw/rtl/kci_pkg.sv -----
// ----------------------------------------------------------------------------
// kci_pkg: shared types and constants
// Payload structs, CSR indexes, sequencer states and the status bundle of the
// multiply/divide unit used by the keyframe camera interpolator.
// ----------------------------------------------------------------------------
package kci_pkg;

   localparam int COORDS         = 6;
   localparam int COORD_IDX_BITS = 3;
   localparam int COORD_BITS     = 32;
   localparam int QUOT_BITS      = 32;
   localparam int KEY_INDEX_BITS = 4;
   localparam int DUR_IN_BITS    = 16;
   localparam int KEY_COUNT_BITS = 5;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 5;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_KEY_COUNT   = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOOP_ENABLE = 1'b1;

   localparam logic ACTION_TICK  = 1'b0;
   localparam logic ACTION_WRITE = 1'b1;

   typedef logic [COORDS-1:0][COORD_BITS-1:0] coord_vec_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_PREP,
      ST_DIFF,
      ST_MSTART,
      ST_WAIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mdu_status_type;

   typedef struct packed {
      logic                             action;
      logic [KEY_INDEX_BITS-1:0]        key_index;
      logic [DUR_IN_BITS-1:0]           key_duration;
      logic signed [COORD_BITS-1:0]     eye_x_in;
      logic signed [COORD_BITS-1:0]     eye_y_in;
      logic signed [COORD_BITS-1:0]     eye_z_in;
      logic signed [COORD_BITS-1:0]     target_x_in;
      logic signed [COORD_BITS-1:0]     target_y_in;
      logic signed [COORD_BITS-1:0]     target_z_in;
   } req_payload_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0]     eye_x_out;
      logic signed [COORD_BITS-1:0]     eye_y_out;
      logic signed [COORD_BITS-1:0]     eye_z_out;
      logic signed [COORD_BITS-1:0]     target_x_out;
      logic signed [COORD_BITS-1:0]     target_y_out;
      logic signed [COORD_BITS-1:0]     target_z_out;
      logic [KEY_INDEX_BITS-1:0]        current_key_out;
      logic                             done_res;
   } rsp_payload_type;

endpackage

// ----- hw/rtl/keyframe_camera_interpolator.sv -----
// ----------------------------------------------------------------------------
// keyframe_camera_interpolator: keyframe camera playback
// Linear interpolation of eye and look-at points between stored keyframes.
//
// Usage:
//   req channel: a word with action = write stores one keyframe (duration,
//   eye, target) at key_index and gives no result. A word with
//   action = tick produces exactly one rsp word with the six interpolated
//   coordinates, the segment start key and the done flag.
//   A tick's rsp word becomes valid in the same cycle in which req_ready
//   returns; the tick first passes a table read and setup, then the six
//   coordinates one after another through a single multiply/divide unit,
//   each with setup, multiply, 32 restoring division steps and write-back,
//   then the load of the output register. req_ready is low during that
//   time, so no new tick is accepted until the last result is loaded.
//   The result sits in an output register; if rsp_ready is low the sequencer
//   holds its last step until the register frees up.
//   csr port: index 0 key_count, index 1 loop_enable; write only while idle.
//   Reset (synchronous) clears key index, frame counter, done flag, and sets
//   key_count = 1, loop_enable = 0. The keyframe table is not cleared.
// ----------------------------------------------------------------------------
module keyframe_camera_interpolator #(
   parameter int MAX_KEYS      = 16,
   parameter int DURATION_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  kci_pkg::req_payload_type             req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output kci_pkg::rsp_payload_type             rsp_payload,
   input  logic                                 csr_we,
   input  logic [kci_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [kci_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int KW = $clog2(MAX_KEYS);
   localparam int NW = $clog2(MAX_KEYS + 1);
   localparam int DB = DURATION_BITS;
   localparam int CB = kci_pkg::COORD_BITS;

   kci_pkg::state_type             state_ff;
   kci_pkg::state_type             state_in;

   logic [kci_pkg::KEY_COUNT_BITS-1:0] key_count_ff;
   logic                               loop_enable_ff;

   logic [KW-1:0]                  cur_ff;
   logic [KW-1:0]                  nxt_ff;
   logic [DB-1:0]                  frame_ff;
   logic                           done_ff;
   logic [DB-1:0]                  dur_ff;
   logic [DB-1:0]                  fr_ff;
   logic [kci_pkg::COORD_IDX_BITS-1:0] c_ff;
   logic [CB-1:0]                  a_ff;
   logic                           neg_ff;
   logic [kci_pkg::QUOT_BITS-1:0]  mag_ff;
   kci_pkg::coord_vec_type         res_ff;
   logic                           rsp_valid_ff;
   kci_pkg::rsp_payload_type       rsp_payload_ff;

   logic                           accept;
   logic                           tick_accept;
   logic                           key_write;
   logic                           mdu_start;
   logic                           rsp_load;
   logic                           last_coord;

   logic [31:0]                    n_wide;
   logic [NW-1:0]                  n_eff;
   logic                           cur_out_range;
   logic [KW-1:0]                  cur_start;
   logic [NW-1:0]                  cur_p1;
   logic [KW-1:0]                  nxt_calc;

   kci_pkg::coord_vec_type         wr_pts;
   kci_pkg::coord_vec_type         cur_pts;
   kci_pkg::coord_vec_type         nxt_pts;
   logic [DB-1:0]                  nxt_dur;
   logic [DB-1:0]                  dur_eff;

   logic [CB:0]                    a_ext;
   logic [CB:0]                    diff;
   logic [CB:0]                    diff_neg;
   logic [CB:0]                    q_ext;
   logic [CB:0]                    sum;

   logic [DB:0]                    f1;
   logic                           seg_end;
   logic                           done_in;

   kci_pkg::mdu_status_type        mdu_status;
   logic [kci_pkg::QUOT_BITS-1:0]  quot;

   // handshake decode
   assign accept      = req_valid && req_ready;
   assign tick_accept = accept && (req_payload.action == kci_pkg::ACTION_TICK);
   assign key_write   = accept && (req_payload.action == kci_pkg::ACTION_WRITE)
                        && (32'(req_payload.key_index) < MAX_KEYS);
   assign last_coord  = (c_ff == kci_pkg::COORD_IDX_BITS'(kci_pkg::COORDS - 1));

   // csr
   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff   <= kci_pkg::KEY_COUNT_BITS'(1);
         loop_enable_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            kci_pkg::CSR_KEY_COUNT: begin
               key_count_ff <= csr_wdata[kci_pkg::KEY_COUNT_BITS-1:0];
            end
            kci_pkg::CSR_LOOP_ENABLE: begin
               loop_enable_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // effective key count and segment keys
   always_comb begin
      if (key_count_ff == '0) begin
         n_wide = 32'd1;
      end else if (32'(key_count_ff) > MAX_KEYS) begin
         n_wide = 32'(MAX_KEYS);
      end else begin
         n_wide = 32'(key_count_ff);
      end
   end

   assign n_eff         = NW'(n_wide);
   assign cur_out_range = (NW'(cur_ff) >= n_eff);
   assign cur_start     = cur_out_range ? '0 : cur_ff;
   assign cur_p1        = NW'(cur_start) + NW'(1);
   assign nxt_calc      = (cur_p1 >= n_eff) ? '0 : KW'(cur_p1);

   // keyframe table
   assign wr_pts[0] = req_payload.eye_x_in;
   assign wr_pts[1] = req_payload.eye_y_in;
   assign wr_pts[2] = req_payload.eye_z_in;
   assign wr_pts[3] = req_payload.target_x_in;
   assign wr_pts[4] = req_payload.target_y_in;
   assign wr_pts[5] = req_payload.target_z_in;

   kci_store #(
      .MAX_KEYS      (MAX_KEYS),
      .DURATION_BITS (DURATION_BITS)
   ) u_store (
      .clock       (clock),
      .wr_en       (key_write),
      .wr_addr     (KW'(req_payload.key_index)),
      .wr_dur      (DB'(req_payload.key_duration)),
      .wr_pts      (wr_pts),
      .rd_cur_addr (cur_ff),
      .rd_nxt_addr (nxt_ff),
      .cur_pts     (cur_pts),
      .nxt_pts     (nxt_pts),
      .nxt_dur     (nxt_dur)
   );

   kci_mdu #(
      .DURATION_BITS (DURATION_BITS)
   ) u_mdu (
      .clock  (clock),
      .reset  (reset),
      .start  (mdu_start),
      .mag    (mag_ff),
      .fr     (fr_ff),
      .dur    (dur_ff),
      .status (mdu_status),
      .quot   (quot)
   );

   // datapath
   assign dur_eff  = (nxt_dur == '0) ? DB'(1) : nxt_dur;
   assign a_ext    = {cur_pts[c_ff][CB-1], cur_pts[c_ff]};
   assign diff     = {nxt_pts[c_ff][CB-1], nxt_pts[c_ff]} - a_ext;
   assign diff_neg = (CB+1)'(0) - diff;
   assign q_ext    = {1'b0, quot};
   assign sum      = neg_ff ? ({a_ff[CB-1], a_ff} - q_ext) : ({a_ff[CB-1], a_ff} + q_ext);

   assign f1       = {1'b0, frame_ff} + (DB+1)'(1);
   assign seg_end  = (f1 >= {1'b0, dur_ff});
   assign done_in  = done_ff || (!loop_enable_ff && (NW'(nxt_ff) == (n_eff - NW'(1))));

   // sequencer: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kci_pkg::ST_IDLE: begin
            if (tick_accept) begin
               state_in = kci_pkg::ST_FETCH;
            end
         end
         kci_pkg::ST_FETCH:  state_in = kci_pkg::ST_PREP;
         kci_pkg::ST_PREP:   state_in = kci_pkg::ST_DIFF;
         kci_pkg::ST_DIFF:   state_in = kci_pkg::ST_MSTART;
         kci_pkg::ST_MSTART: state_in = kci_pkg::ST_WAIT;
         kci_pkg::ST_WAIT: begin
            if (mdu_status.done) begin
               state_in = last_coord ? kci_pkg::ST_FINISH : kci_pkg::ST_DIFF;
            end
         end
         kci_pkg::ST_FINISH: begin
            if (rsp_load) begin
               state_in = kci_pkg::ST_IDLE;
            end
         end
         default: state_in = kci_pkg::ST_IDLE;
      endcase
   end

   // sequencer: outputs
   always_comb begin
      req_ready = 1'b0;
      mdu_start = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         kci_pkg::ST_IDLE:   req_ready = 1'b1;
         kci_pkg::ST_MSTART: mdu_start = 1'b1;
         kci_pkg::ST_FINISH: rsp_load  = !rsp_valid_ff || rsp_ready;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kci_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // playback state
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff   <= '0;
         nxt_ff   <= '0;
         frame_ff <= '0;
         done_ff  <= 1'b0;
      end else if (tick_accept) begin
         cur_ff <= cur_start;
         nxt_ff <= nxt_calc;
         if (cur_out_range) begin
            frame_ff <= '0;
         end
      end else if (rsp_load) begin
         done_ff <= done_in && seg_end ? 1'b1 : done_ff;
         if (seg_end) begin
            cur_ff   <= nxt_ff;
            frame_ff <= '0;
         end else begin
            frame_ff <= f1[DB-1:0];
         end
      end
   end

   // per-tick working registers
   always_ff @(posedge clock) begin
      if (state_ff == kci_pkg::ST_PREP) begin
         dur_ff <= dur_eff;
         fr_ff  <= (frame_ff > dur_eff) ? dur_eff : frame_ff;
      end
      if (state_ff == kci_pkg::ST_DIFF) begin
         a_ff   <= cur_pts[c_ff];
         neg_ff <= diff[CB];
         mag_ff <= diff[CB] ? diff_neg[CB-1:0] : diff[CB-1:0];
      end
      if (state_ff == kci_pkg::ST_WAIT && mdu_status.done) begin
         res_ff[c_ff] <= sum[CB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ff <= '0;
      end else if (state_ff == kci_pkg::ST_PREP) begin
         c_ff <= '0;
      end else if (state_ff == kci_pkg::ST_WAIT && mdu_status.done && !last_coord) begin
         c_ff <= c_ff + kci_pkg::COORD_IDX_BITS'(1);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_payload_ff.eye_x_out       <= res_ff[0];
         rsp_payload_ff.eye_y_out       <= res_ff[1];
         rsp_payload_ff.eye_z_out       <= res_ff[2];
         rsp_payload_ff.target_x_out    <= res_ff[3];
         rsp_payload_ff.target_y_out    <= res_ff[4];
         rsp_payload_ff.target_z_out    <= res_ff[5];
         rsp_payload_ff.current_key_out <= kci_pkg::KEY_INDEX_BITS'(cur_ff);
         rsp_payload_ff.done_res        <= seg_end ? done_in : done_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // checks
   a_mdu_busy_in_wait: assert property (@(posedge clock) disable iff (reset)
      mdu_status.busy |-> (state_ff == kci_pkg::ST_WAIT))
      else $error("multiply/divide unit busy outside wait state");

   a_coord_range: assert property (@(posedge clock) disable iff (reset)
      (32'(c_ff) < kci_pkg::COORDS))
      else $error("coordinate index out of range");

   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> done_ff)
      else $error("done flag cleared without reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_payload_ff)))
      else $error("pending result word overwritten");

endmodule

// ----- hw/rtl/kci_store.sv -----
// ----------------------------------------------------------------------------
// kci_store: keyframe table
// One write port for a whole keyframe; registered reads of the segment start
// point, the segment end point and the end key's duration.
// ----------------------------------------------------------------------------
module kci_store #(
   parameter int MAX_KEYS      = 16,
   parameter int DURATION_BITS = 16
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [$clog2(MAX_KEYS)-1:0]     wr_addr,
   input  logic [DURATION_BITS-1:0]        wr_dur,
   input  kci_pkg::coord_vec_type          wr_pts,
   input  logic [$clog2(MAX_KEYS)-1:0]     rd_cur_addr,
   input  logic [$clog2(MAX_KEYS)-1:0]     rd_nxt_addr,
   output kci_pkg::coord_vec_type          cur_pts,
   output kci_pkg::coord_vec_type          nxt_pts,
   output logic [DURATION_BITS-1:0]        nxt_dur
);

   logic [kci_pkg::COORDS-1:0][kci_pkg::COORD_BITS-1:0] pts_mem [MAX_KEYS];
   logic [DURATION_BITS-1:0]                            dur_mem [MAX_KEYS];

   kci_pkg::coord_vec_type     cur_pts_ff;
   kci_pkg::coord_vec_type     nxt_pts_ff;
   logic [DURATION_BITS-1:0]   nxt_dur_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pts_mem[wr_addr] <= wr_pts;
         dur_mem[wr_addr] <= wr_dur;
      end
   end

   always_ff @(posedge clock) begin
      cur_pts_ff <= pts_mem[rd_cur_addr];
      nxt_pts_ff <= pts_mem[rd_nxt_addr];
      nxt_dur_ff <= dur_mem[rd_nxt_addr];
   end

   assign cur_pts = cur_pts_ff;
   assign nxt_pts = nxt_pts_ff;
   assign nxt_dur = nxt_dur_ff;

endmodule

// ----- hw/rtl/kci_mdu.sv -----
// ----------------------------------------------------------------------------
// kci_mdu: shared multiply/divide unit
// Computes floor(mag * fr / dur) for fr <= dur: a multiply, then a
// restoring division producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kci_mdu #(
   parameter int DURATION_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [kci_pkg::QUOT_BITS-1:0]      mag,
   input  logic [DURATION_BITS-1:0]           fr,
   input  logic [DURATION_BITS-1:0]           dur,
   output kci_pkg::mdu_status_type            status,
   output logic [kci_pkg::QUOT_BITS-1:0]      quot
);

   localparam int QB = kci_pkg::QUOT_BITS;
   localparam int RW = DURATION_BITS + QB;
   localparam int CW = $clog2(QB);

   logic [RW-1:0]            rq_ff;
   logic [RW-1:0]            rq_in;
   logic [CW-1:0]            cnt_ff;
   logic                     busy_ff;
   logic                     done_ff;
   logic [RW-1:0]            prod;
   logic [DURATION_BITS:0]   trial;
   logic [DURATION_BITS:0]   trial_sub;
   logic                     q_bit;
   logic [DURATION_BITS-1:0] rem_in;

   assign prod      = RW'(mag) * RW'(fr);
   assign trial     = rq_ff[RW-1:QB-1];
   assign trial_sub = trial - {1'b0, dur};
   assign q_bit     = (trial >= {1'b0, dur});
   assign rem_in    = q_bit ? trial_sub[DURATION_BITS-1:0] : trial[DURATION_BITS-1:0];
   assign rq_in     = {rem_in, rq_ff[QB-2:0], q_bit};

   always_ff @(posedge clock) begin
      if (start) begin
         rq_ff <= prod;
      end else if (busy_ff) begin
         rq_ff <= rq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CW'(1);
            if (cnt_ff == CW'(QB - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quot        = rq_ff[QB-1:0];

endmodule

// ----- tb/keyframe_camera_interpolator_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_camera_interpolator_test: self-checking bench for camera playback
// Loads keyframes and plays ticks through the req channel, with random gaps on
// both sides. Each rsp word is compared with a behavioral camera model, or
// with a fixed pose in scripted checks. A short scripted opening covers
// field extremes, zero and overrun durations, and shrinking the key count.
// Random phases then sweep key_count and loop_enable.
// ----------------------------------------------------------------------------
module keyframe_camera_interpolator_test;

   localparam int  NUM_KEYS    = 16;
   localparam int  PHASE_WORDS = 110;
   localparam int  CSR_SETTLE  = 8;
   localparam int  DRAIN       = 300;
   localparam longint LIMIT    = 2_000_000;

   typedef struct {
      bit                       is_csr;
      bit [4:0]                 count;
      bit                       loop_on;
      kci_pkg::req_payload_type word;
      bit                       typed;
      kci_pkg::rsp_payload_type want;
   } script_row_type;

   logic                                clock       = 1'b0;
   logic                                reset       = 1'b1;
   logic                                req_valid   = 1'b0;
   logic                                req_ready;
   kci_pkg::req_payload_type            req_payload = '0;
   logic                                rsp_valid;
   logic                                rsp_ready   = 1'b0;
   kci_pkg::rsp_payload_type            rsp_payload;
   logic                                csr_we      = 1'b0;
   logic [kci_pkg::CSR_INDEX_BITS-1:0]  csr_index   = kci_pkg::CSR_KEY_COUNT;
   logic [kci_pkg::CSR_DATA_BITS-1:0]   csr_wdata   = '0;

   // camera model state
   logic [15:0]        key_dur [NUM_KEYS];
   logic signed [31:0] key_pts [NUM_KEYS][kci_pkg::COORDS];
   int                 cur_key_q   = 0;
   logic [15:0]        frame_q     = '0;
   bit                 done_q      = 1'b0;
   logic [4:0]         key_count_q = 5'd1;
   bit                 loop_q      = 1'b0;

   kci_pkg::rsp_payload_type pending_poses [$];
   script_row_type           opening_script [$];
   int                       bad_count = 0;
   bit                       calm      = 1'b0;
   longint                   cycles    = 0;

   keyframe_camera_interpolator uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("%0t: timeout", $time);
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic advance_camera(input kci_pkg::req_payload_type w, output bit made,
                                 output kci_pkg::rsp_payload_type pose);
      logic signed [31:0] p [kci_pkg::COORDS];
      int     n, cur, nxt;
      longint dur, fr, f1, a, b;
      made = 1'b0;
      pose = '0;
      n = (key_count_q == 0) ? 1 : ((key_count_q > NUM_KEYS) ? NUM_KEYS : int'(key_count_q));
      if (w.action == kci_pkg::ACTION_WRITE) begin
         key_dur[w.key_index] = w.key_duration;
         key_pts[w.key_index] = '{w.eye_x_in, w.eye_y_in, w.eye_z_in,
                                  w.target_x_in, w.target_y_in, w.target_z_in};
      end else begin
         if (cur_key_q >= n) begin
            cur_key_q = 0;
            frame_q   = '0;
         end
         cur = cur_key_q;
         nxt = (cur + 1 >= n) ? 0 : cur + 1;
         dur = key_dur[nxt];
         if (dur == 0) dur = 1;
         fr = frame_q;
         if (fr > dur) fr = dur;
         for (int i = 0; i < kci_pkg::COORDS; i++) begin
            a = key_pts[cur][i];
            b = key_pts[nxt][i];
            p[i] = a + ((b - a) * fr) / dur;
         end
         pose.eye_x_out       = p[0];
         pose.eye_y_out       = p[1];
         pose.eye_z_out       = p[2];
         pose.target_x_out    = p[3];
         pose.target_y_out    = p[4];
         pose.target_z_out    = p[5];
         pose.current_key_out = 4'(cur);
         f1 = longint'(frame_q) + 1;
         if (f1 >= dur) begin
            cur_key_q = nxt;
            frame_q   = '0;
            if (!loop_q && cur_key_q == n - 1) done_q = 1'b1;
         end else begin
            frame_q = f1[15:0];
         end
         pose.done_res = done_q;
         made = 1'b1;
      end
   endtask

   function automatic kci_pkg::req_payload_type make_key(input logic [3:0] slot,
                                                         input logic [15:0] dur,
                                                         input logic [31:0] ex, ey, ez,
                                                         input logic [31:0] tx, ty, tz);
      kci_pkg::req_payload_type w;
      w.action       = kci_pkg::ACTION_WRITE;
      w.key_index    = slot;
      w.key_duration = dur;
      w.eye_x_in     = ex;
      w.eye_y_in     = ey;
      w.eye_z_in     = ez;
      w.target_x_in  = tx;
      w.target_y_in  = ty;
      w.target_z_in  = tz;
      return w;
   endfunction

   function automatic kci_pkg::rsp_payload_type pose_of(input kci_pkg::req_payload_type k,
                                                        input logic [3:0] key,
                                                        input bit done);
      kci_pkg::rsp_payload_type r;
      r.eye_x_out       = k.eye_x_in;
      r.eye_y_out       = k.eye_y_in;
      r.eye_z_out       = k.eye_z_in;
      r.target_x_out    = k.target_x_in;
      r.target_y_out    = k.target_y_in;
      r.target_z_out    = k.target_z_in;
      r.current_key_out = key;
      r.done_res        = done;
      return r;
   endfunction

   function automatic logic [31:0] random_coord();
      int pick;
      pick = $urandom_range(99);
      if (pick < 4) return 32'h7FFF_FFFF;
      if (pick < 8) return 32'h8000_0000;
      if (pick < 10) return '0;
      return $urandom;
   endfunction

   function automatic kci_pkg::req_payload_type random_word();
      kci_pkg::req_payload_type w;
      int pick;
      pick = $urandom_range(99);
      if (pick < 70)      w.key_duration = 16'($urandom_range(6));
      else if (pick < 90) w.key_duration = 16'($urandom_range(40, 7));
      else if (pick < 97) w.key_duration = 16'($urandom);
      else                w.key_duration = 16'hFFFF;
      w.action      = ($urandom_range(99) < 60) ? kci_pkg::ACTION_TICK
                                                : kci_pkg::ACTION_WRITE;
      w.key_index   = 4'($urandom_range(NUM_KEYS - 1));
      w.eye_x_in    = random_coord();
      w.eye_y_in    = random_coord();
      w.eye_z_in    = random_coord();
      w.target_x_in = random_coord();
      w.target_y_in = random_coord();
      w.target_z_in = random_coord();
      return w;
   endfunction

   function automatic void script_word(input kci_pkg::req_payload_type w);
      script_row_type row;
      row = '{is_csr: 1'b0, count: '0, loop_on: 1'b0, word: w, typed: 1'b0, want: '0};
      opening_script.insert(opening_script.size(), row);
   endfunction

   function automatic void script_checked(input kci_pkg::req_payload_type w,
                                          input kci_pkg::rsp_payload_type want);
      script_row_type row;
      row = '{is_csr: 1'b0, count: '0, loop_on: 1'b0, word: w, typed: 1'b1, want: want};
      opening_script.insert(opening_script.size(), row);
   endfunction

   function automatic void script_config(input bit [4:0] count, input bit loop_on);
      script_row_type row;
      row = '{is_csr: 1'b1, count: count, loop_on: loop_on, word: '0,
              typed: 1'b0, want: '0};
      opening_script.insert(opening_script.size(), row);
   endfunction

   task automatic send_word(input kci_pkg::req_payload_type w, input bit typed,
                            input kci_pkg::rsp_payload_type want);
      bit made;
      kci_pkg::rsp_payload_type pose;
      while (!calm && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      advance_camera(w, made, pose);
      if (made) pending_poses.insert(pending_poses.size(), typed ? want : pose);
   endtask

   // csr writes only once the block has drained
   task automatic set_config(input bit [4:0] count, input bit loop_on);
      req_valid <= 1'b0;
      while (pending_poses.size() != 0) @(posedge clock);
      repeat (CSR_SETTLE) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= kci_pkg::CSR_KEY_COUNT;
      csr_wdata <= count;
      @(posedge clock);
      csr_index <= kci_pkg::CSR_LOOP_ENABLE;
      csr_wdata <= kci_pkg::CSR_DATA_BITS'(loop_on);
      @(posedge clock);
      csr_we      <= 1'b0;
      key_count_q = count;
      loop_q      = loop_on;
   endtask

   task automatic check_field(input string name, input logic [31:0] want, got);
      if (got !== want) begin
         $display("%0t: %s expected %h got %h", $time, name, want, got);
         bad_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_side
      kci_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_poses.size() == 0) begin
            $display("%0t: unexpected rsp word %h", $time, rsp_payload);
            bad_count++;
         end else begin
            want = pending_poses.pop_front();
            check_field("eye_x_out", want.eye_x_out, rsp_payload.eye_x_out);
            check_field("eye_y_out", want.eye_y_out, rsp_payload.eye_y_out);
            check_field("eye_z_out", want.eye_z_out, rsp_payload.eye_z_out);
            check_field("target_x_out", want.target_x_out, rsp_payload.target_x_out);
            check_field("target_y_out", want.target_y_out, rsp_payload.target_y_out);
            check_field("target_z_out", want.target_z_out, rsp_payload.target_z_out);
            check_field("current_key_out", want.current_key_out,
                        rsp_payload.current_key_out);
            check_field("done_res", want.done_res, rsp_payload.done_res);
         end
      end
      rsp_ready <= calm || ($urandom_range(99) >= 35);
   end

   initial begin
      kci_pkg::req_payload_type  key0, tick;
      bit [4:0]                  phase_count [10];
      bit                        phase_loop  [10];

      phase_count = '{5'd16, 5'd3, 5'd0, 5'd17, 5'd2, 5'd31, 5'd1, 5'd5, 5'd16, 5'd4};
      phase_loop  = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0};
      tick = '0;
      tick.action = kci_pkg::ACTION_TICK;
      key0 = make_key(4'd0, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                      32'hFFFF_FFFF, 32'h1, 32'h1234_5678);

      // single key after reset: frame counts up, no step, done low
      script_word(key0);
      script_checked(tick, pose_of(key0, 4'd0, 1'b0));
      script_checked(tick, pose_of(key0, 4'd0, 1'b0));
      script_word(make_key(4'd1, 16'h0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      script_word(make_key(4'd2, 16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      for (int k = 3; k < NUM_KEYS; k++)
         script_word(make_key(4'(k), 16'($urandom_range(4, 1)), $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom));
      // two keys, zero-duration target, then shorten key 0 below the frame count
      script_config(5'd2, 1'b1);
      script_word(tick);
      script_word(tick);
      script_word(tick);
      script_word(make_key(4'd0, 16'd1, key0.eye_x_in, key0.eye_y_in, key0.eye_z_in,
                           key0.target_x_in, key0.target_y_in, key0.target_z_in));
      script_checked(tick, pose_of(key0, 4'd1, 1'b0));
      script_word(tick);
      // current key now beyond the shrunken count
      script_config(5'd1, 1'b1);
      script_checked(tick, pose_of(key0, 4'd0, 1'b0));
      script_config(5'd31, 1'b1);
      script_word(tick);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_script[r]) begin
         if (opening_script[r].is_csr)
            set_config(opening_script[r].count, opening_script[r].loop_on);
         else
            send_word(opening_script[r].word, opening_script[r].typed,
                      opening_script[r].want);
      end

      for (int ph = 0; ph < 10; ph++) begin
         set_config(phase_count[ph], phase_loop[ph]);
         calm = (ph == 4);
         repeat (PHASE_WORDS) send_word(random_word(), 1'b0, '0);
      end
      calm = 1'b0;

      req_valid <= 1'b0;
      while (pending_poses.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (bad_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
